FILE: sv/fsre_pkg.sv
// Shared constants, types and register reset values of the fuzzy rule evaluator.
`timescale 1ns / 1ps

package fsre_pkg;

   // Rule count and data widths
   localparam int NUM_RULES = 7;
   localparam int DEG_W     = 16;                 // Q1.15 membership degree
   localparam int COEF_W    = 16;                 // Q3.12 consequent
   localparam int PROD_W    = DEG_W + 1 + COEF_W; // strength times consequent
   localparam int DEN_W     = DEG_W + 3;          // sum of seven strengths
   localparam int NUM_W     = PROD_W + 2;         // sum of seven products
   localparam int MAG_W     = NUM_W - 1;          // numerator magnitude
   localparam int QUO_W     = 16;                 // quotient magnitude, at most 2^15
   localparam int CSR_IDX_W = 3;

   typedef logic [DEG_W-1:0]         degree_type;
   typedef logic signed [COEF_W-1:0] coef_type;

   // Rule positions, also the register index of each rule's consequent
   localparam int RULE_COLD_FALL   = 0;
   localparam int RULE_COLD_STEADY = 1;
   localparam int RULE_COLD_RISE   = 2;
   localparam int RULE_OPTIMAL     = 3;
   localparam int RULE_HOT_FALL    = 4;
   localparam int RULE_HOT_STEADY  = 5;
   localparam int RULE_HOT_RISE    = 6;

   // Consequent values after reset
   localparam coef_type RULE_RESET [NUM_RULES] = '{
      -16'sd6144, 16'sd6144, -16'sd2048, 16'sd0, 16'sd0, 16'sd3072, 16'sd6144
   };

   // Word entering the divider
   typedef struct packed {
      logic             valid;
      logic             neg;
      logic             none;
      logic [MAG_W-1:0] mag;
      logic [DEN_W-1:0] den;
   } div_in_type;

   // Word leaving the divider
   typedef struct packed {
      logic             valid;
      logic             neg;
      logic             none;
      logic [QUO_W-1:0] quo;
   } div_out_type;

endpackage

FILE: sv/fsre_if.sv
// Channel interfaces of the fuzzy rule evaluator: degrees in, result out, register writes.
`timescale 1ns / 1ps

interface fsre_req_if;
   import fsre_pkg::*;
   logic       valid;
   logic       ready;
   degree_type cold_degree;
   degree_type optimal_degree;
   degree_type hot_degree;
   degree_type falling_degree;
   degree_type steady_degree;
   degree_type rising_degree;

   modport source (
      output valid, cold_degree, optimal_degree, hot_degree,
             falling_degree, steady_degree, rising_degree,
      input  ready
   );
   modport sink (
      input  valid, cold_degree, optimal_degree, hot_degree,
             falling_degree, steady_degree, rising_degree,
      output ready
   );
endinterface

interface fsre_rsp_if;
   import fsre_pkg::*;
   logic     valid;
   logic     ready;
   coef_type adjustment;
   logic     no_rule_fired;

   modport source (output valid, adjustment, no_rule_fired, input ready);
   modport sink (input valid, adjustment, no_rule_fired, output ready);
endinterface

interface fsre_csr_if;
   import fsre_pkg::*;
   logic                 valid;
   logic                 ready;
   logic [CSR_IDX_W-1:0] index;
   coef_type             data;

   modport source (output valid, index, data, input ready);
   modport sink (input valid, index, data, output ready);
endinterface

FILE: sv/fsre_div.sv
// Pipelined restoring divider: one quotient bit per stage, numerator magnitude over strength sum.
`timescale 1ns / 1ps

module fsre_div (
   input  logic                 clock,
   input  logic                 reset,
   input  logic                 enable,
   input  fsre_pkg::div_in_type div_in,
   output fsre_pkg::div_out_type div_out
);
   import fsre_pkg::*;

   // Per-stage registers; stage j settles quotient bit QUO_W-1-j
   logic             valid_ff [QUO_W];
   logic             neg_ff   [QUO_W];
   logic             none_ff  [QUO_W];
   logic [MAG_W-1:0] rem_ff   [QUO_W];
   logic [DEN_W-1:0] den_ff   [QUO_W];
   logic [QUO_W-1:0] quo_ff   [QUO_W];

   for (genvar j = 0; j < QUO_W; j++) begin : g_step
      localparam int BIT = QUO_W - 1 - j;

      logic             valid_cur;
      logic             neg_cur;
      logic             none_cur;
      logic [MAG_W-1:0] rem_cur;
      logic [DEN_W-1:0] den_cur;
      logic [QUO_W-1:0] quo_cur;
      logic [MAG_W-1:0] trial;
      logic             fits;
      logic [MAG_W-1:0] rem_in;
      logic [QUO_W-1:0] quo_in;

      // Stage input: divider port or previous stage
      if (j == 0) begin : g_first
         assign valid_cur = div_in.valid;
         assign neg_cur   = div_in.neg;
         assign none_cur  = div_in.none;
         assign rem_cur   = div_in.mag;
         assign den_cur   = div_in.den;
         assign quo_cur   = '0;
      end else begin : g_next
         assign valid_cur = valid_ff[j-1];
         assign neg_cur   = neg_ff[j-1];
         assign none_cur  = none_ff[j-1];
         assign rem_cur   = rem_ff[j-1];
         assign den_cur   = den_ff[j-1];
         assign quo_cur   = quo_ff[j-1];
      end

      // Compare and subtract the shifted divisor
      assign trial  = MAG_W'(den_cur) << BIT;
      assign fits   = (rem_cur >= trial);
      assign rem_in = fits ? (rem_cur - trial) : rem_cur;
      always_comb begin
         quo_in      = quo_cur;
         quo_in[BIT] = fits;
      end

      always_ff @(posedge clock) begin
         if (reset) begin
            valid_ff[j] <= 1'b0;
         end else if (enable) begin
            valid_ff[j] <= valid_cur;
         end
      end

      always_ff @(posedge clock) begin
         if (enable) begin
            neg_ff[j]  <= neg_cur;
            none_ff[j] <= none_cur;
            rem_ff[j]  <= rem_in;
            den_ff[j]  <= den_cur;
            quo_ff[j]  <= quo_in;
         end
      end
   end

   assign div_out.valid = valid_ff[QUO_W-1];
   assign div_out.neg   = neg_ff[QUO_W-1];
   assign div_out.none  = none_ff[QUO_W-1];
   assign div_out.quo   = quo_ff[QUO_W-1];

endmodule

FILE: sv/fuzzy_sugeno_rule_evaluator.sv
// Top level of the zero-order Sugeno rule evaluator: rule strengths, weighted sums, divide.
`timescale 1ns / 1ps

// Takes one word of six membership degrees per cycle while not stalled and returns
// the strength-weighted average of the seven rule consequents, with the
// quotient truncated toward zero. The pipeline is four stages of rule strength,
// products, sums and magnitude, sixteen stages of the divider (one quotient bit
// each) and the output register; items follow each other back to back. While
// the output word waits, the pipeline keeps moving as long as its last stage
// is empty. Consequent registers are written through the csr channel, which is
// always ready; an index past the last rule is ignored.
module fuzzy_sugeno_rule_evaluator (
   input logic        clock,
   input logic        reset,
   fsre_req_if.sink   req_if,
   fsre_rsp_if.source rsp_if,
   fsre_csr_if.sink   csr_if
);
   import fsre_pkg::*;

   // Consequent registers
   coef_type rule_ff [NUM_RULES];

   // Pipeline control
   logic        advance;
   logic        out_free;
   div_in_type  div_in;
   div_out_type div_out;

   // Stage 1: rule strengths
   logic       s1_valid_ff;
   degree_type str_ff [NUM_RULES];
   degree_type str_in [NUM_RULES];

   // Stage 2: products and strength sum
   logic                     s2_valid_ff;
   logic signed [PROD_W-1:0] prod_ff [NUM_RULES];
   logic signed [PROD_W-1:0] prod_in [NUM_RULES];
   logic [DEN_W-1:0]         s2_den_ff;
   logic [DEN_W-1:0]         s2_den_in;

   // Stage 3: numerator sum
   logic                    s3_valid_ff;
   logic signed [NUM_W-1:0] num_ff;
   logic signed [NUM_W-1:0] num_in;
   logic [DEN_W-1:0]        s3_den_ff;

   // Stage 4: sign and magnitude
   logic             s4_valid_ff;
   logic             neg_ff;
   logic             none_ff;
   logic [MAG_W-1:0] mag_ff;
   logic [MAG_W-1:0] mag_in;
   logic [DEN_W-1:0] s4_den_ff;

   // Output register
   logic                    rsp_valid_ff;
   coef_type                adjust_ff;
   coef_type                adjust_in;
   logic                    none_out_ff;
   logic signed [QUO_W:0]   signed_quo;

   // Stall only when the last stage holds a word the output cannot take
   assign out_free       = !rsp_valid_ff || rsp_if.ready;
   assign advance        = !div_out.valid || out_free;
   assign req_if.ready   = advance;
   assign csr_if.ready   = 1'b1;

   // Consequent register writes
   always_ff @(posedge clock) begin
      if (reset) begin
         for (int i = 0; i < NUM_RULES; i++) begin
            rule_ff[i] <= RULE_RESET[i];
         end
      end else if (csr_if.valid && (int'(csr_if.index) < NUM_RULES)) begin
         rule_ff[csr_if.index] <= csr_if.data;
      end
   end

   // Fuzzy AND of temperature and slope degrees
   always_comb begin
      str_in[RULE_COLD_FALL]   = (req_if.cold_degree < req_if.falling_degree) ?
                                 req_if.cold_degree : req_if.falling_degree;
      str_in[RULE_COLD_STEADY] = (req_if.cold_degree < req_if.steady_degree) ?
                                 req_if.cold_degree : req_if.steady_degree;
      str_in[RULE_COLD_RISE]   = (req_if.cold_degree < req_if.rising_degree) ?
                                 req_if.cold_degree : req_if.rising_degree;
      str_in[RULE_OPTIMAL]     = req_if.optimal_degree;
      str_in[RULE_HOT_FALL]    = (req_if.hot_degree < req_if.falling_degree) ?
                                 req_if.hot_degree : req_if.falling_degree;
      str_in[RULE_HOT_STEADY]  = (req_if.hot_degree < req_if.steady_degree) ?
                                 req_if.hot_degree : req_if.steady_degree;
      str_in[RULE_HOT_RISE]    = (req_if.hot_degree < req_if.rising_degree) ?
                                 req_if.hot_degree : req_if.rising_degree;
   end

   // Weighted products and strength sum
   always_comb begin
      s2_den_in = '0;
      for (int i = 0; i < NUM_RULES; i++) begin
         prod_in[i] = $signed({1'b0, str_ff[i]}) * rule_ff[i];
         s2_den_in  = s2_den_in + DEN_W'(str_ff[i]);
      end
   end

   // Numerator sum
   always_comb begin
      num_in = '0;
      for (int i = 0; i < NUM_RULES; i++) begin
         num_in = num_in + NUM_W'(prod_ff[i]);
      end
   end

   // Magnitude for the unsigned divider
   assign mag_in = num_ff[NUM_W-1] ? MAG_W'(-num_ff) : MAG_W'(num_ff);

   // Front pipeline valid bits
   always_ff @(posedge clock) begin
      if (reset) begin
         s1_valid_ff <= 1'b0;
         s2_valid_ff <= 1'b0;
         s3_valid_ff <= 1'b0;
         s4_valid_ff <= 1'b0;
      end else if (advance) begin
         s1_valid_ff <= req_if.valid;
         s2_valid_ff <= s1_valid_ff;
         s3_valid_ff <= s2_valid_ff;
         s4_valid_ff <= s3_valid_ff;
      end
   end

   // Front pipeline payload
   always_ff @(posedge clock) begin
      if (advance) begin
         str_ff    <= str_in;
         prod_ff   <= prod_in;
         s2_den_ff <= s2_den_in;
         num_ff    <= num_in;
         s3_den_ff <= s2_den_ff;
         neg_ff    <= num_ff[NUM_W-1];
         none_ff   <= (s3_den_ff == '0);
         mag_ff    <= mag_in;
         s4_den_ff <= s3_den_ff;
      end
   end

   assign div_in.valid = s4_valid_ff;
   assign div_in.neg   = neg_ff;
   assign div_in.none  = none_ff;
   assign div_in.mag   = mag_ff;
   assign div_in.den   = s4_den_ff;

   fsre_div u_div (
      .clock   (clock),
      .reset   (reset),
      .enable  (advance),
      .div_in  (div_in),
      .div_out (div_out)
   );

   // Restore the sign and clamp to 16 bits
   assign signed_quo = div_out.neg ? -$signed({1'b0, div_out.quo}) :
                                      $signed({1'b0, div_out.quo});
   always_comb begin
      priority if (div_out.none) begin
         adjust_in = '0;
      end else if (signed_quo > (QUO_W+1)'(32767)) begin
         adjust_in = 16'sh7FFF;
      end else if (signed_quo < -(QUO_W+1)'(32768)) begin
         adjust_in = 16'sh8000;
      end else begin
         adjust_in = signed_quo[COEF_W-1:0];
      end
   end

   // Output register
   always_ff @(posedge clock) begin
      if (reset) begin
         rsp_valid_ff <= 1'b0;
      end else if (out_free) begin
         rsp_valid_ff <= div_out.valid;
      end
   end

   always_ff @(posedge clock) begin
      if (out_free) begin
         adjust_ff   <= adjust_in;
         none_out_ff <= div_out.none;
      end
   end

   assign rsp_if.valid         = rsp_valid_ff;
   assign rsp_if.adjustment    = adjust_ff;
   assign rsp_if.no_rule_fired = none_out_ff;

endmodule

FILE: tb/fsre_adjust_check.sv
// Result checker for the fuzzy rule evaluator: predicts each adjustment and compares.
`timescale 1ns / 1ps

module fsre_adjust_check (
   input  logic clock,
   input  logic reset,
   fsre_req_if  req_tap,
   fsre_rsp_if  rsp_tap,
   fsre_csr_if  csr_tap,
   output int   mismatches,
   output int   outstanding,
   output int   results_seen,
   output int   empty_results
);
   import fsre_pkg::*;

   // One predicted result word, tagged with the number of its degree word
   typedef struct {
      coef_type adjustment;
      logic     no_rule_fired;
      int       serial;
   } adjust_expect_type;

   coef_type          rule_coef [NUM_RULES];
   adjust_expect_type pending_adjustments [$];
   int                words_in;

   // Fuzzy AND of two degrees
   function automatic longint fuzzy_and(input degree_type a, input degree_type b);
      return (a < b) ? longint'(a) : longint'(b);
   endfunction

   // Strength-weighted average of the consequents, quotient truncated toward zero
   function automatic void weighted_adjustment(
      input  degree_type cold, opt, hot, fall, steady, rise,
      output coef_type   adj,
      output logic       none
   );
      longint strength [NUM_RULES];
      longint num;
      longint den;
      longint quo;
      int     i;
      strength[RULE_COLD_FALL]   = fuzzy_and(cold, fall);
      strength[RULE_COLD_STEADY] = fuzzy_and(cold, steady);
      strength[RULE_COLD_RISE]   = fuzzy_and(cold, rise);
      strength[RULE_OPTIMAL]     = longint'(opt);
      strength[RULE_HOT_FALL]    = fuzzy_and(hot, fall);
      strength[RULE_HOT_STEADY]  = fuzzy_and(hot, steady);
      strength[RULE_HOT_RISE]    = fuzzy_and(hot, rise);
      num = 0;
      den = 0;
      for (i = 0; i < NUM_RULES; i++) begin
         num += strength[i] * longint'(rule_coef[i]);
         den += strength[i];
      end
      if (den == 0) begin
         adj  = '0;
         none = 1'b1;
      end else begin
         quo = num / den;
         // guard only, the average cannot leave the consequent range
         if (quo > 32767) quo = 32767;
         if (quo < -32768) quo = -32768;
         adj  = coef_type'(quo);
         none = 1'b0;
      end
   endfunction

   // One line per mismatch, and count it
   task automatic report_mismatch(input string what, input int got, input int want,
                                  input int serial);
      $display("%0t ns: word %0d, %s: got %0d, expected %0d",
               $time, serial, what, got, want);
      mismatches++;
   endtask

   // Watch all three channels at the rising edge
   always @(posedge clock) begin : watch
      adjust_expect_type want;
      if (reset) begin
         rule_coef = RULE_RESET;
         pending_adjustments.delete();
         words_in      = 0;
         mismatches    = 0;
         results_seen  = 0;
         empty_results = 0;
      end else begin
         // register writes; an index past the last rule changes nothing
         if (csr_tap.valid && csr_tap.ready && csr_tap.index < NUM_RULES)
            rule_coef[csr_tap.index] = csr_tap.data;

         if (req_tap.valid && req_tap.ready) begin
            weighted_adjustment(req_tap.cold_degree, req_tap.optimal_degree,
                                req_tap.hot_degree, req_tap.falling_degree,
                                req_tap.steady_degree, req_tap.rising_degree,
                                want.adjustment, want.no_rule_fired);
            want.serial = words_in;
            words_in++;
            pending_adjustments.push_back(want);
         end

         if (rsp_tap.valid && rsp_tap.ready) begin
            if (pending_adjustments.size() == 0) begin
               report_mismatch("result word with none pending, adjustment",
                               int'(rsp_tap.adjustment), 0, -1);
            end else begin
               want = pending_adjustments.pop_front();
               results_seen++;
               if (want.no_rule_fired) empty_results++;
               if (rsp_tap.adjustment !== want.adjustment)
                  report_mismatch("adjustment", int'(rsp_tap.adjustment),
                                  int'(want.adjustment), want.serial);
               if (rsp_tap.no_rule_fired !== want.no_rule_fired)
                  report_mismatch("no_rule_fired", int'(rsp_tap.no_rule_fired),
                                  int'(want.no_rule_fired), want.serial);
            end
         end
      end
      outstanding = pending_adjustments.size();
   end

endmodule

FILE: tb/tb_top.sv
// Testbench top of the fuzzy rule evaluator: stimulus, pacing, register loads and verdict.
`timescale 1ns / 1ps

module tb_top;
   import fsre_pkg::*;

   // Slots of the six degrees when a word is built as an array
   localparam int SLOT_COLD    = 0;
   localparam int SLOT_OPTIMAL = 1;
   localparam int SLOT_HOT     = 2;
   localparam int SLOT_FALLING = 3;
   localparam int SLOT_STEADY  = 4;
   localparam int SLOT_RISING  = 5;
   localparam int NUM_SLOTS    = 6;

   localparam coef_type COEF_MIN = 16'sh8000;
   localparam coef_type COEF_MAX = 16'sh7FFF;

   typedef struct packed {
      degree_type cold, optimal, hot, falling, steady, rising;
   } degree_word_type;

   typedef enum {
      RULES_RESET, RULES_ALL_MIN, RULES_ALL_MAX, RULES_ALTERNATE, RULES_RANDOM, RULES_TINY
   } rule_setting_type;

   logic     clock;
   logic     reset;
   int       req_idle_pct;
   int       rsp_stall_pct;
   int       hold_left;
   int       words_sent;
   int       settings_loaded;
   int       mismatches;
   int       outstanding;
   int       results_seen;
   int       empty_results;
   coef_type next_rules [NUM_RULES];

   fsre_req_if req_ch ();
   fsre_rsp_if rsp_ch ();
   fsre_csr_if csr_ch ();

   fuzzy_sugeno_rule_evaluator uut (
      .clock  (clock),
      .reset  (reset),
      .req_if (req_ch),
      .rsp_if (rsp_ch),
      .csr_if (csr_ch)
   );

   fsre_adjust_check chk (
      .clock         (clock),
      .reset         (reset),
      .req_tap       (req_ch),
      .rsp_tap       (rsp_ch),
      .csr_tap       (csr_ch),
      .mismatches    (mismatches),
      .outstanding   (outstanding),
      .results_seen  (results_seen),
      .empty_results (empty_results)
   );

   // 100 MHz clock
   initial begin
      clock = 1'b0;
      forever #5 clock = ~clock;
   end

   // Watchdog, far beyond the slowest correct run
   initial begin
      #5_000_000;
      $display("Mismatches found");
      $finish;
   end

   // Result receiver: long hold-off when asked, otherwise random stalls
   initial begin
      rsp_ch.ready = 1'b0;
      forever begin
         @(negedge clock);
         if (hold_left > 0) begin
            rsp_ch.ready = 1'b0;
            hold_left--;
         end else begin
            rsp_ch.ready = ($urandom_range(99) >= rsp_stall_pct);
         end
      end
   end

   // Offer one degree word, after a random gap, and wait until it is taken
   task automatic send_word(input degree_word_type w);
      while (req_idle_pct > 0 && $urandom_range(99) < req_idle_pct) begin
         @(negedge clock);
         req_ch.valid = 1'b0;
      end
      @(negedge clock);
      req_ch.valid          = 1'b1;
      req_ch.cold_degree    = w.cold;
      req_ch.optimal_degree = w.optimal;
      req_ch.hot_degree     = w.hot;
      req_ch.falling_degree = w.falling;
      req_ch.steady_degree  = w.steady;
      req_ch.rising_degree  = w.rising;
      do @(posedge clock); while (req_ch.ready !== 1'b1);
      words_sent++;
   endtask

   task automatic send_degrees(input int c, o, h, f, s, r);
      degree_word_type w;
      w = '{degree_type'(c), degree_type'(o), degree_type'(h),
            degree_type'(f), degree_type'(s), degree_type'(r)};
      send_word(w);
   endtask

   // Stop offering and wait until every predicted result has come back
   task automatic drain;
      @(negedge clock);
      req_ch.valid = 1'b0;
      while (outstanding != 0) @(negedge clock);
   endtask

   // Pick a consequent setting and write it, plus one write past the last rule
   task automatic load_setting(input rule_setting_type setting);
      int i;
      for (i = 0; i < NUM_RULES; i++) begin
         case (setting)
            RULES_RESET:     next_rules[i] = RULE_RESET[i];
            RULES_ALL_MIN:   next_rules[i] = COEF_MIN;
            RULES_ALL_MAX:   next_rules[i] = COEF_MAX;
            RULES_ALTERNATE: next_rules[i] = (i % 2 == 0) ? COEF_MIN : COEF_MAX;
            RULES_TINY:      next_rules[i] = coef_type'($urandom_range(16) - 8);
            default: begin
               case ($urandom_range(7))
                  0:       next_rules[i] = COEF_MIN;
                  1:       next_rules[i] = COEF_MAX;
                  default: next_rules[i] = coef_type'($urandom_range(65535));
               endcase
            end
         endcase
      end
      for (i = 0; i <= NUM_RULES; i++) begin
         @(negedge clock);
         csr_ch.valid = 1'b1;
         csr_ch.index = CSR_IDX_W'(i);
         csr_ch.data  = (i < NUM_RULES) ? next_rules[i] : coef_type'($urandom_range(65535));
         do @(posedge clock); while (csr_ch.ready !== 1'b1);
      end
      @(negedge clock);
      csr_ch.valid = 1'b0;
      settings_loaded++;
   endtask

   // Random degree word, shaped toward corners and empty rule sets
   function automatic degree_word_type random_word();
      degree_type d [NUM_SLOTS];
      int mode;
      int r;
      int i;
      mode = $urandom_range(99);
      for (i = 0; i < NUM_SLOTS; i++) d[i] = degree_type'($urandom_range(32768));
      if (mode < 12) begin
         // whole 16-bit range, degrees past 1.0 included
         for (i = 0; i < NUM_SLOTS; i++) d[i] = degree_type'($urandom_range(65535));
      end else if (mode < 24) begin
         // nothing fires: optimal and one whole side at zero
         d[SLOT_OPTIMAL] = '0;
         if ($urandom_range(1) == 0) begin
            d[SLOT_COLD] = '0;
            d[SLOT_HOT]  = '0;
         end else begin
            d[SLOT_FALLING] = '0;
            d[SLOT_STEADY]  = '0;
            d[SLOT_RISING]  = '0;
         end
      end else if (mode < 38) begin
         // corners: zero, full scale, tiny or all ones
         for (i = 0; i < NUM_SLOTS; i++) begin
            case ($urandom_range(3))
               0:       d[i] = '0;
               1:       d[i] = 16'h8000;
               2:       d[i] = degree_type'($urandom_range(15, 1));
               default: d[i] = 16'hFFFF;
            endcase
         end
      end else if (mode < 48) begin
         // one rule alone
         for (i = 0; i < NUM_SLOTS; i++) d[i] = '0;
         r = $urandom_range(NUM_RULES - 1);
         if (r == RULE_OPTIMAL) begin
            d[SLOT_OPTIMAL] = degree_type'($urandom_range(65535, 1));
         end else begin
            d[(r < RULE_OPTIMAL) ? SLOT_COLD : SLOT_HOT] =
               degree_type'($urandom_range(65535, 1));
            d[SLOT_FALLING + ((r < RULE_OPTIMAL) ? r - RULE_COLD_FALL : r - RULE_HOT_FALL)] =
               degree_type'($urandom_range(65535, 1));
         end
      end
      return '{d[SLOT_COLD], d[SLOT_OPTIMAL], d[SLOT_HOT],
               d[SLOT_FALLING], d[SLOT_STEADY], d[SLOT_RISING]};
   endfunction

   // One random phase: setting, pacing, optional output hold-off
   task automatic run_phase(input rule_setting_type setting, input int idle, input int stall,
                            input int hold, input int count);
      load_setting(setting);
      req_idle_pct  = idle;
      rsp_stall_pct = stall;
      hold_left     = hold;
      repeat (count) send_word(random_word());
      drain();
   endtask

   // Main sequence
   initial begin
      reset                 = 1'b1;
      req_ch.valid          = 1'b0;
      req_ch.cold_degree    = '0;
      req_ch.optimal_degree = '0;
      req_ch.hot_degree     = '0;
      req_ch.falling_degree = '0;
      req_ch.steady_degree  = '0;
      req_ch.rising_degree  = '0;
      csr_ch.valid          = 1'b0;
      csr_ch.index          = '0;
      csr_ch.data           = '0;
      req_idle_pct          = 0;
      rsp_stall_pct         = 0;
      hold_left             = 0;
      words_sent            = 0;
      settings_loaded       = 0;
      repeat (2) @(posedge clock);
      @(negedge clock);
      reset = 1'b0;

      // directed words under the reset consequents
      send_degrees(0, 0, 0, 0, 0, 0);                         // nothing fires
      send_degrees(32768, 32768, 32768, 32768, 32768, 32768);
      send_degrees(65535, 65535, 65535, 65535, 65535, 65535);
      send_degrees(0, 32768, 0, 0, 0, 0);                     // optimal alone
      send_degrees(0, 0, 0, 32768, 32768, 32768);             // no temperature
      send_degrees(32768, 0, 32768, 0, 0, 0);                 // no slope
      send_degrees(32768, 0, 0, 32768, 0, 0);                 // each pair rule alone
      send_degrees(32768, 0, 0, 0, 32768, 0);
      send_degrees(32768, 0, 0, 0, 0, 32768);
      send_degrees(0, 0, 32768, 32768, 0, 0);
      send_degrees(0, 0, 32768, 0, 32768, 0);
      send_degrees(0, 0, 32768, 0, 0, 32768);
      send_degrees(0, 1, 0, 0, 0, 0);
      send_degrees(16'hAAAA, 16'h5555, 16'hAAAA, 16'h5555, 16'hAAAA, 16'h5555);
      send_degrees(3, 0, 0, 1, 1, 1);                         // negative, truncated
      send_degrees(32768, 0, 0, 100, 32768, 0);               // minimum picks the slope
      drain();

      // directed words under the extreme consequents
      load_setting(RULES_ALL_MIN);
      send_degrees(32768, 32768, 32768, 32768, 32768, 32768);
      send_degrees(7, 3, 0, 0, 65535, 0);
      drain();
      load_setting(RULES_ALL_MAX);
      send_degrees(65535, 65535, 65535, 65535, 65535, 65535);
      send_degrees(0, 0, 5, 9, 0, 2);
      drain();
      load_setting(RULES_ALTERNATE);
      send_degrees(1, 0, 0, 1, 2, 0);
      send_degrees(0, 1, 65535, 0, 0, 65535);
      drain();

      // random phases under different settings and pacing
      run_phase(RULES_RANDOM,    0,  0,   0, 220);
      run_phase(RULES_ALTERNATE, 81, 0,   0, 180);
      run_phase(RULES_RANDOM,    0,  81,  0, 180);
      run_phase(RULES_RESET,     21, 21,  0, 200);
      run_phase(RULES_RANDOM,    0,  0, 150, 120);   // output held off, pipeline fills
      run_phase(RULES_TINY,      0,  0,   0, 130);

      // let any stray result show up
      repeat (40) @(negedge clock);

      $display("Covered %0d degree words and %0d results, %0d of them with no rule fired,",
               words_sent, results_seen, empty_results);
      $display("over %0d consequent settings, free-running, stalled and held-off pacing.",
               settings_loaded);
      if (mismatches == 0 && outstanding == 0) begin
         $display("No mismatches found");
      end else begin
         $display("Mismatches found");
      end
      $finish;
   end

endmodule

FILE: sim.f
sv/fsre_pkg.sv
sv/fsre_if.sv
sv/fsre_div.sv
sv/fuzzy_sugeno_rule_evaluator.sv
tb/fsre_adjust_check.sv
tb/tb_top.sv
